// File: src/awf_pkg.sv
// Shared constants and types for the adaptive weight filter.
package awf_pkg;

    // Filter tuning constants
    localparam int CREDIT_START = 50;
    localparam int CREDIT_DIV   = 20;
    localparam int NOISE_BAND   = 2;
    localparam int SCALAR_MAX   = 8;
    localparam int DIVISOR_BIAS = 1;

    // Shared divider geometry: two quotient bits per step
    localparam int DIV_W       = 36;
    localparam int DSOR_W      = 16;
    localparam int STEP_W      = 5;
    localparam int DELTA_BITS  = 26;
    localparam int DELTA_PAD   = DIV_W - DELTA_BITS;
    localparam int DELTA_STEPS = DELTA_BITS / 2;
    localparam int WGT_STEPS   = DIV_W / 2;

    // Config register map, in port index order; the last code is not mapped
    typedef enum logic [2:0] {
        REG_GAIN,
        REG_STEP,
        REG_TARE,
        REG_MOTION_BAND,
        REG_MOTION_DELAY,
        REG_ZERO_BAND,
        REG_ZERO_DELAY,
        REG_UNUSED
    } t_reg_idx;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_cmd;

endpackage

// File: src/awf_div.sv
// Iterative restoring divider, two quotient bits per cycle, unsigned operands.
module awf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  awf_pkg::t_div_cmd           i_cmd,
    input  logic [awf_pkg::DIV_W-1:0]   i_dividend,
    input  logic [awf_pkg::DSOR_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [awf_pkg::DIV_W-1:0]   o_quotient,
    output logic [awf_pkg::DSOR_W-1:0]  o_remainder
);
    import awf_pkg::*;

    typedef struct packed {
        logic              q_bit;
        logic [DSOR_W-1:0] rem;
    } t_step;

    logic [DSOR_W-1:0] r_rem;
    logic [DSOR_W-1:0] r_dsor;
    logic [DIV_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    t_step             s1;
    t_step             s2;

    // one restoring step: shift in a dividend bit, subtract if it fits
    function automatic t_step div_step(input logic [DSOR_W-1:0] rem,
                                       input logic              in_bit,
                                       input logic [DSOR_W-1:0] dsor);
        logic [DSOR_W+1:0] trial;
        t_step             res;
        trial = {1'b0, rem, in_bit} - {2'b00, dsor};
        if (trial[DSOR_W+1]) begin
            res.q_bit = 1'b0;
            res.rem   = {rem[DSOR_W-2:0], in_bit};
        end else begin
            res.q_bit = 1'b1;
            res.rem   = trial[DSOR_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        s1 = div_step(r_rem, r_quo[DIV_W-1], r_dsor);
        s2 = div_step(s1.rem, r_quo[DIV_W-2], r_dsor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dsor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= s2.rem;
            r_quo <= {r_quo[DIV_W-3:0], s1.q_bit, s2.q_bit};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// File: src/adaptive_weight_filter.sv
// Adaptive load-cell filter: smoothed count, rounded net weight, motion and zero flags.
//
//  Channel   Direction  Handshake                   Payload
//  input     in         i_in_valid / o_in_stall     i_net_count
//  result    out        o_out_valid / i_out_stall   o_net_weight, o_smoothed_count,
//                                                   o_in_motion, o_at_zero
//  config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
//  One transfer in gives one transfer out. The next input transfer is taken only once
//  the result is loaded; an item runs longer while the direction credit is at or past
//  its start threshold, as the shared divider adds a bonus pass. Synchronous
//  active-low reset clears state and config to defaults; no clearing pass.
//  o_in_stall is high from acceptance until the result is loaded into the output
//  register; a stalled result holds the final step until the output register frees.
module adaptive_weight_filter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [24:0] i_net_count,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [34:0] o_net_weight,
    output logic signed [25:0] o_smoothed_count,
    output logic               o_in_motion,
    output logic               o_at_zero,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [33:0]        i_cfg_data
);
    import awf_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_BONUS  = 4'd1;   // start delta/CREDIT_DIV or skip it
    localparam logic [3:0] S_BWAIT  = 4'd2;
    localparam logic [3:0] S_CREDIT = 4'd3;   // credit update with saturation
    localparam logic [3:0] S_DSEL   = 4'd4;   // divisor from credit magnitude
    localparam logic [3:0] S_FGO    = 4'd5;   // start delta/divisor
    localparam logic [3:0] S_FWAIT  = 4'd6;
    localparam logic [3:0] S_PROD   = 4'd7;   // gain * smoothed count
    localparam logic [3:0] S_RGO    = 4'd8;   // start weight/step
    localparam logic [3:0] S_RWAIT  = 4'd9;
    localparam logic [3:0] S_FLAGS  = 4'd10;  // flags, counters, output load

    localparam logic signed [58:0] ROUND_HALF = 59'sd8388608;
    localparam logic signed [36:0] W35_MAX    = 37'sd17179869183;
    localparam logic signed [36:0] W35_MIN    = -37'sd17179869184;

    // configuration
    logic        [31:0] r_gain;
    logic        [15:0] r_step;
    logic signed [33:0] r_tare;
    logic        [23:0] r_mband;
    logic        [14:0] r_mdelay;
    logic        [23:0] r_zband;
    logic        [14:0] r_zdelay;

    // control and filter state
    logic        [3:0]  r_state, n_state;
    logic signed [15:0] r_credit, n_credit;
    logic signed [25:0] r_fc, n_fc;
    logic signed [34:0] r_prev;
    logic        [15:0] r_still, n_still;
    logic        [15:0] r_empty, n_empty;
    logic               r_motion, n_motion;
    logic               r_zero, n_zero;
    logic               r_out_valid;

    // datapath
    logic signed [26:0] r_delta;
    logic signed [26:0] r_bonus;
    logic        [15:0] r_dsor, n_dsor;
    logic signed [58:0] r_prod;
    logic signed [34:0] r_a;
    logic signed [34:0] r_weight, n_weight;

    // shared divider
    t_div_cmd           div_cmd;
    logic [DIV_W-1:0]   div_dividend;
    logic [DSOR_W-1:0]  div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;
    logic [DSOR_W-1:0]  div_rem;

    logic               in_xfer;
    logic               out_free;
    logic        [26:0] delta_mag;
    logic signed [16:0] credit_ext;
    logic        [16:0] credit_mag;
    logic               bonus_on;
    logic               credit_clr;
    logic signed [28:0] delta_sgn;
    logic signed [28:0] credit_sum;
    logic        [7:0]  s_val;
    logic signed [28:0] q_trunc;
    logic signed [16:0] r_trunc;
    logic signed [28:0] fc_base;
    logic signed [28:0] fc_sum;
    logic signed [58:0] a_sum;
    logic signed [34:0] a_val;
    logic        [35:0] a_mag;
    logic        [15:0] step_eff;
    logic signed [36:0] a_ext;
    logic signed [36:0] rem_ext;
    logic signed [36:0] rnd_val;
    logic signed [36:0] wt_full;
    logic signed [35:0] w_diff;
    logic        [35:0] diff_mag;
    logic        [35:0] w_mag;
    logic               is_still;
    logic               is_empty;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // magnitudes and signs shared by several steps
    assign delta_mag  = r_delta[26] ? 27'(-r_delta) : 27'(r_delta);
    assign credit_ext = 17'(r_credit);
    assign credit_mag = credit_ext[16] ? 17'(-credit_ext) : 17'(credit_ext);
    assign bonus_on   = credit_mag >= 17'(CREDIT_START);
    assign step_eff   = (r_step == '0) ? 16'd1 : r_step;

    // credit: cleared on reversal or inside the noise band, else grows with bonus
    always_comb begin
        credit_clr = (!r_delta[26] && r_credit[15])
                  || ((r_delta[26] || (r_delta == '0)) && !r_credit[15] && (r_credit != '0))
                  || (delta_mag < 27'(NOISE_BAND));
        if (r_delta[26])           delta_sgn = -29'sd1;
        else if (r_delta != '0)    delta_sgn = 29'sd1;
        else                       delta_sgn = 29'sd0;
        credit_sum = 29'(r_bonus) + 29'(r_credit) + delta_sgn;
        if (credit_clr)                      n_credit = '0;
        else if (credit_sum > 29'sd32767)    n_credit = 16'sh7FFF;
        else if (credit_sum < -29'sd32768)   n_credit = 16'sh8000;
        else                                 n_credit = credit_sum[15:0];
    end

    // divisor = max(0, SCALAR_MAX - |credit|)^2 + DIVISOR_BIAS
    always_comb begin
        if (credit_mag >= 17'(SCALAR_MAX)) s_val = '0;
        else                               s_val = 8'(SCALAR_MAX) - credit_mag[7:0];
        n_dsor = ({8'd0, s_val} * {8'd0, s_val}) + 16'(DIVISOR_BIAS);
    end

    // fc + (delta/d) truncated toward zero, from the truncated quotient and remainder:
    // the sign of fc*d + delta picks floor or ceiling of delta/d
    always_comb begin
        q_trunc = r_delta[26] ? -$signed(29'(div_quo[26:0])) : $signed(29'(div_quo[26:0]));
        r_trunc = r_delta[26] ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});
        fc_base = 29'(r_fc) + q_trunc;
        if ((fc_base > 29'sd0) || ((fc_base == 29'sd0) && !r_trunc[16]))
            fc_sum = fc_base - ((r_trunc < 17'sd0) ? 29'sd1 : 29'sd0);
        else
            fc_sum = fc_base + ((r_trunc > 17'sd0) ? 29'sd1 : 29'sd0);
        n_fc = fc_sum[25:0];
    end

    // weight: floor((P + half) / 2^24) then floor to a multiple of the step via remainder
    always_comb begin
        a_sum   = r_prod + ROUND_HALF;
        a_val   = a_sum[58:24];
        a_mag   = a_val[34] ? 36'(-36'(a_val)) : 36'(a_val);
        a_ext   = 37'(r_a);
        rem_ext = $signed({21'd0, div_rem});
        if (!r_a[34])
            rnd_val = a_ext - rem_ext;
        else if (div_rem != '0)
            rnd_val = a_ext + rem_ext - $signed({21'd0, step_eff});
        else
            rnd_val = a_ext;
        wt_full = rnd_val - 37'(r_tare);
        if (wt_full > W35_MAX)      n_weight = W35_MAX[34:0];
        else if (wt_full < W35_MIN) n_weight = W35_MIN[34:0];
        else                        n_weight = wt_full[34:0];
    end

    // motion and zero detection with settle counters
    always_comb begin
        w_diff   = 36'(r_weight) - 36'(r_prev);
        diff_mag = w_diff[35] ? 36'(-w_diff) : 36'(w_diff);
        w_mag    = r_weight[34] ? 36'(-36'(r_weight)) : 36'(r_weight);
        is_still = 36'(r_mband) > diff_mag;
        is_empty = w_mag < 36'(r_zband);
        n_motion = r_motion;
        n_still  = r_still;
        if (is_still) begin
            if (r_still > {1'b0, r_mdelay}) n_motion = 1'b0;
            if (r_still != 16'hFFFF)       n_still  = r_still + 1'b1;
        end else begin
            n_still  = '0;
            n_motion = 1'b1;
        end
        n_zero  = r_zero;
        n_empty = r_empty;
        if (is_empty) begin
            if (r_empty > {1'b0, r_zdelay}) n_zero  = 1'b1;
            if (r_empty != 16'hFFFF)       n_empty = r_empty + 1'b1;
        end else begin
            n_empty = '0;
            n_zero  = 1'b0;
        end
    end

    // divider command per state
    always_comb begin
        div_cmd.start = 1'b0;
        div_cmd.steps = STEP_W'(DELTA_STEPS);
        div_dividend  = {delta_mag[DELTA_BITS-1:0], {DELTA_PAD{1'b0}}};
        div_divisor   = DSOR_W'(CREDIT_DIV);
        case (r_state)
            S_BONUS: div_cmd.start = bonus_on;
            S_FGO: begin
                div_cmd.start = 1'b1;
                div_divisor   = r_dsor;
            end
            S_RGO: begin
                div_cmd.start = 1'b1;
                div_cmd.steps = STEP_W'(WGT_STEPS);
                div_dividend  = a_mag;
                div_divisor   = step_eff;
            end
            default: ;
        endcase
    end

    awf_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (div_cmd),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_xfer) n_state = S_BONUS;
            S_BONUS:  n_state = bonus_on ? S_BWAIT : S_CREDIT;
            S_BWAIT:  if (div_done) n_state = S_CREDIT;
            S_CREDIT: n_state = S_DSEL;
            S_DSEL:   n_state = S_FGO;
            S_FGO:    n_state = S_FWAIT;
            S_FWAIT:  if (div_done) n_state = S_PROD;
            S_PROD:   n_state = S_RGO;
            S_RGO:    n_state = S_RWAIT;
            S_RWAIT:  if (div_done) n_state = S_FLAGS;
            S_FLAGS:  if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state, filter state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_credit    <= '0;
            r_fc        <= '0;
            r_prev      <= '0;
            r_still     <= '0;
            r_empty     <= '0;
            r_motion    <= 1'b0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
            r_gain      <= 32'd16777216;
            r_step      <= 16'd1;
            r_tare      <= '0;
            r_mband     <= '0;
            r_mdelay    <= '0;
            r_zband     <= '0;
            r_zdelay    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CREDIT) r_credit <= n_credit;
            if ((r_state == S_FWAIT) && div_done) r_fc <= n_fc;
            if ((r_state == S_FLAGS) && out_free) begin
                r_prev      <= r_weight;
                r_still     <= n_still;
                r_empty     <= n_empty;
                r_motion    <= n_motion;
                r_zero      <= n_zero;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_GAIN:         r_gain   <= i_cfg_data[31:0];
                    REG_STEP:         r_step   <= i_cfg_data[15:0];
                    REG_TARE:         r_tare   <= i_cfg_data;
                    REG_MOTION_BAND:  r_mband  <= i_cfg_data[23:0];
                    REG_MOTION_DELAY: r_mdelay <= i_cfg_data[14:0];
                    REG_ZERO_BAND:    r_zband  <= i_cfg_data[23:0];
                    REG_ZERO_DELAY:   r_zdelay <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) r_delta <= 27'(i_net_count) - 27'(r_fc);
        if (r_state == S_BONUS) r_bonus <= '0;
        if ((r_state == S_BWAIT) && div_done) begin
            r_bonus <= r_delta[26] ? -$signed(div_quo[26:0]) : $signed(div_quo[26:0]);
        end
        if (r_state == S_DSEL) r_dsor <= n_dsor;
        if (r_state == S_PROD) r_prod <= $signed({1'b0, r_gain}) * r_fc;
        if (r_state == S_RGO) r_a <= a_val;
        if ((r_state == S_RWAIT) && div_done) r_weight <= n_weight;
        if ((r_state == S_FLAGS) && out_free) begin
            o_net_weight     <= r_weight;
            o_smoothed_count <= r_fc;
            o_in_motion      <= n_motion;
            o_at_zero        <= n_zero;
        end
    end

    assign o_out_valid = r_out_valid;

    // an accepted item always starts the bonus step next
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_BONUS))
        else $error("accepted item did not start the sequence");

    // divider results only arrive while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_BWAIT || r_state == S_FWAIT || r_state == S_RWAIT))
        else $error("divider finished outside a wait state");

    // a result only appears from the final step
    a_out_from_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_FLAGS))
        else $error("result valid without final step");

endmodule

// File: verif/tb_adaptive_weight_filter.sv
// Testbench for adaptive_weight_filter: directed table, then random traffic against a predictor.
module tb_adaptive_weight_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import awf_pkg::*;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    // One result transfer
    typedef struct packed {
        logic signed [34:0] net_weight;
        logic signed [25:0] smoothed_count;
        logic               in_motion;
        logic               at_zero;
    } t_weight_result;

    // Directed row: either a register write or one count; typed rows carry their own answer
    typedef struct packed {
        t_row_kind          kind;
        t_reg_idx           idx;
        logic [33:0]        data;
        logic signed [24:0] count;
        logic               typed;
        t_weight_result     want;
    } t_stim_row;

    localparam int     NUM_ROWS     = 38;
    localparam int     RANDOM_ITEMS = 1100;
    localparam longint W35_MAX      = 64'sd17179869183;
    localparam longint W35_MIN      = -64'sd17179869184;

    localparam t_stim_row DIRECTED_ROWS [NUM_ROWS] = '{
        // out of reset: zero in gives zero out, and any change (even none) flags motion
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd0, 1'b1, '{35'sd0, 26'sd0, 1'b1, 1'b0}},
        // tare extremes with an empty filter: weight is just minus tare
        '{ROW_WRITE, REG_TARE, 34'h1_FFFF_FFFF, 25'sd0, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd0, 1'b1, '{-35'sd8589934591, 26'sd0, 1'b1, 1'b0}},
        '{ROW_WRITE, REG_TARE, 34'h2_0000_0000, 25'sd0, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd0, 1'b1, '{35'sd8589934592, 26'sd0, 1'b1, 1'b0}},
        // widest bands: scale settles, motion clears and zero sets after one sample
        '{ROW_WRITE, REG_TARE, 34'd0, 25'sd0, 1'b0, '0},
        '{ROW_WRITE, REG_MOTION_BAND, 34'hFF_FFFF, 25'sd0, 1'b0, '0},
        '{ROW_WRITE, REG_ZERO_BAND, 34'hFF_FFFF, 25'sd0, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd0, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd1, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, -25'sd1, 1'b0, '0},
        // largest gain and step, full-scale count held so the credit builds
        '{ROW_WRITE, REG_GAIN, 34'hFFFF_FFFF, 25'sd0, 1'b0, '0},
        '{ROW_WRITE, REG_STEP, 34'hFFFF, 25'sd0, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd16777215, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd16777215, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd16777215, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd16777215, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd16777215, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd16777215, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd16777215, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd16777215, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd16777215, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd16777215, 1'b0, '0},
        // swing to the most negative count: the credit builds again, now downward
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'h100_0000, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'h100_0000, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'h100_0000, 1'b0, '0},
        // zero gain, and a zero step that must act as one
        '{ROW_WRITE, REG_GAIN, 34'd0, 25'sd0, 1'b0, '0},
        '{ROW_WRITE, REG_STEP, 34'd0, 25'sd0, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd1000, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, -25'sd1000, 1'b0, '0},
        // write to the unmapped index must leave every register alone
        '{ROW_WRITE, REG_UNUSED, 34'h3_FFFF_FFFF, 25'sd0, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd5, 1'b0, '0},
        // longest settle delays, back to unit gain
        '{ROW_WRITE, REG_MOTION_DELAY, 34'h7FFF, 25'sd0, 1'b0, '0},
        '{ROW_WRITE, REG_ZERO_DELAY, 34'h7FFF, 25'sd0, 1'b0, '0},
        '{ROW_WRITE, REG_GAIN, 34'h0100_0000, 25'sd0, 1'b0, '0},
        '{ROW_WRITE, REG_STEP, 34'd1, 25'sd0, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, 25'sd3, 1'b0, '0},
        '{ROW_ITEM,  REG_GAIN, 34'd0, -25'sd3, 1'b0, '0}
    };

    // DUT-side signals; everything the TB drives starts at a known value
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic signed [24:0] net_count = '0;
    logic               out_stall = 1'b0;
    logic               cfg_we    = 1'b0;
    t_reg_idx           cfg_index = REG_GAIN;
    logic [33:0]        cfg_data  = '0;

    logic               in_stall;
    logic               out_valid;
    logic signed [34:0] net_weight;
    logic signed [25:0] smoothed_count;
    logic               in_motion;
    logic               at_zero;

    // Predictor copy of the registers (reset values)
    logic [31:0]        gain_q         = 32'h0100_0000;
    logic [15:0]        step_q         = 16'd1;
    logic signed [33:0] tare_q         = '0;
    logic [23:0]        motion_band_q  = '0;
    logic [14:0]        motion_delay_q = '0;
    logic [23:0]        zero_band_q    = '0;
    logic [14:0]        zero_delay_q   = '0;

    // Predictor copy of the filter state
    logic signed [25:0] filt_count  = '0;
    logic signed [15:0] dir_credit  = '0;
    logic signed [34:0] last_weight = '0;
    logic [15:0]        still_run   = '0;
    logic [15:0]        empty_run   = '0;
    logic               motion_flag = 1'b0;
    logic               zero_flag   = 1'b0;

    t_weight_result expected_weights[$];
    int             fail_count   = 0;
    int             items_sent   = 0;
    logic           quiet_window = 1'b0;   // no random idling on either side while set

    adaptive_weight_filter u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_net_count      (net_count),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_net_weight     (net_weight),
        .o_smoothed_count (smoothed_count),
        .o_in_motion      (in_motion),
        .o_at_zero        (at_zero),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    // 4 ns clock
    initial begin
        forever #2 clk = ~clk;
    end

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the predicted filter by one count and return the result it owes
    function automatic t_weight_result filter_step(input logic signed [24:0] sample);
        longint         delta, bonus, credit, shrink, divisor, step, num, den, quo, weight;
        t_weight_result res;
        delta = longint'(sample) - longint'(filt_count);
        bonus = 0;
        // at or past the start threshold the credit also takes a share of the change
        if (magnitude(longint'(dir_credit)) >= CREDIT_START) bonus = delta / CREDIT_DIV;
        // reversal or noise-level change drops the credit; else step it and clip to 16 bits
        if ((delta >= 0 && dir_credit < 0) || (delta <= 0 && dir_credit > 0) ||
            magnitude(delta) < NOISE_BAND) begin
            dir_credit = '0;
        end else begin
            credit = bonus + longint'(dir_credit) + ((delta > 0) ? 1 : ((delta < 0) ? -1 : 0));
            if (credit > 32767) credit = 32767;
            if (credit < -32768) credit = -32768;
            dir_credit = 16'(credit);
        end
        // more credit, smaller divisor, faster tracking; sum truncates toward zero
        shrink = SCALAR_MAX - magnitude(longint'(dir_credit));
        if (shrink < 0) shrink = 0;
        divisor = shrink * shrink + DIVISOR_BIAS;
        if (divisor < 1) divisor = 1;
        filt_count = 26'((longint'(filt_count) * divisor + delta) / divisor);
        // Q.24 product plus half an LSB, floored toward minus infinity to a multiple of the step
        step = (step_q == 16'd0) ? 1 : longint'(step_q);
        num = longint'(gain_q) * longint'(filt_count) + (longint'(1) << 23);
        den = step << 24;
        quo = num / den;
        if ((num % den != 0) && (num < 0)) quo = quo - 1;
        weight = quo * step - longint'(tare_q);
        if (weight > W35_MAX) weight = W35_MAX;
        if (weight < W35_MIN) weight = W35_MIN;
        // motion: clears only after more than motion_delay still samples
        if (longint'(motion_band_q) > magnitude(weight - longint'(last_weight))) begin
            if (still_run > {1'b0, motion_delay_q} && motion_flag) motion_flag = 1'b0;
            if (still_run != 16'hFFFF) still_run = still_run + 16'd1;
        end else begin
            still_run   = '0;
            motion_flag = 1'b1;
        end
        // zero: sets only after more than zero_delay empty samples
        if (magnitude(weight) < longint'(zero_band_q)) begin
            if (empty_run > {1'b0, zero_delay_q} && !zero_flag) zero_flag = 1'b1;
            if (empty_run != 16'hFFFF) empty_run = empty_run + 16'd1;
        end else begin
            empty_run = '0;
            zero_flag = 1'b0;
        end
        last_weight        = 35'(weight);
        res.net_weight     = last_weight;
        res.smoothed_count = filt_count;
        res.in_motion      = motion_flag;
        res.at_zero        = zero_flag;
        return res;
    endfunction

    // Random register value: zero, all ones, signed extremes, full random or a modest value
    function automatic logic [33:0] pick_field(input int bits, input int modest_max);
        logic [33:0] mask;
        mask = (34'd1 << bits) - 34'd1;
        case ($urandom_range(6, 0))
            0:       return '0;
            1:       return mask;
            2:       return mask >> 1;
            3:       return 34'd1 << (bits - 1);
            4:       return 34'({$urandom, $urandom}) & mask;
            default: return 34'($urandom_range(modest_max, 0));
        endcase
    endfunction

    // Register write, one cycle of write enable; predictor copy follows at once
    // (only called while idle, so no transfer can see the early update)
    task automatic write_reg(input t_reg_idx idx, input logic [33:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_GAIN:         gain_q         = value[31:0];
            REG_STEP:         step_q         = value[15:0];
            REG_TARE:         tare_q         = value;
            REG_MOTION_BAND:  motion_band_q  = value[23:0];
            REG_MOTION_DELAY: motion_delay_q = value[14:0];
            REG_ZERO_BAND:    zero_band_q    = value[23:0];
            REG_ZERO_DELAY:   zero_delay_q   = value[14:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Hold the input side until every owed result has been transferred out.
    // Always waits for a falling edge so valid never gets two updates in one step.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (expected_weights.size() != 0);
    endtask

    // One count transfer; entered and left at a falling edge with valid possibly still high
    task automatic send_count(input logic signed [24:0] sample, input logic typed,
                              input t_weight_result typed_want);
        t_weight_result predicted;
        while (!quiet_window && $urandom_range(99, 0) < 9) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        net_count <= sample;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = filter_step(sample);
        expected_weights.push_back(typed ? typed_want : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    // New random register setting, written with the block idle
    task automatic configure_random();
        wait_results_drained();
        write_reg(REG_GAIN,         pick_field(32, 1 << 26));
        write_reg(REG_STEP,         pick_field(16, 100));
        write_reg(REG_TARE,         pick_field(34, 2000));
        write_reg(REG_MOTION_BAND,  pick_field(24, 3000));
        write_reg(REG_MOTION_DELAY, pick_field(15, 6));
        write_reg(REG_ZERO_BAND,    pick_field(24, 3000));
        write_reg(REG_ZERO_DELAY,   pick_field(15, 6));
    endtask

    // One stretch of counts: mostly monotonic ramps (these build and saturate the credit)
    // and noisy plateaus (these let motion and zero settle), with some pure noise
    task automatic send_segment();
        int                 shape, len, wobble, max_step;
        logic               rising;
        longint             level, stride;
        logic signed [24:0] sample;
        len    = $urandom_range(80, 20);
        shape  = $urandom_range(9, 0);
        rising = 1'($urandom);
        wobble = $urandom_range(3, 0);
        case ($urandom_range(2, 0))
            0:       max_step = $urandom_range(40, 2);
            1:       max_step = $urandom_range(65536, 2);
            default: max_step = $urandom_range(1 << 20, 2);
        endcase
        if (shape <= 4) begin
            // start near the far end so the ramp has room to run
            level = rising ? -64'sd16777216 + longint'($urandom_range(4000000, 0))
                           : 64'sd16777215 - longint'($urandom_range(4000000, 0));
        end else if ($urandom_range(1, 0) == 0) begin
            level = longint'($urandom_range(200, 0)) - 100;
        end else begin
            level = longint'($urandom_range(33554431, 0)) - 16777216;
        end
        for (int n = 0; n < len; n++) begin
            if (shape <= 4) begin
                stride = longint'($urandom_range(max_step, 2));
                level  = rising ? level + stride : level - stride;
                if (level > 16777215) level = 16777215;
                if (level < -16777216) level = -16777216;
                sample = 25'(level);
            end else if (shape <= 7) begin
                sample = 25'(level + longint'($urandom_range(2 * wobble, 0)) - wobble);
            end else begin
                sample = 25'($urandom);
            end
            // a stretch in the middle of the run with no random idling
            quiet_window <= (items_sent >= 500 && items_sent < 700);
            // now and then let the pipe run dry before the next transfer
            if ($urandom_range(199, 0) == 0) wait_results_drained();
            send_count(sample, 1'b0, '0);
        end
    endtask

    // Result side stalls at random outside the quiet stretch
    always @(negedge clk) begin
        out_stall <= !quiet_window && ($urandom_range(99, 0) < 9);
    end

    // Scoreboard: each result transfer against the oldest owed result
    always @(posedge clk) begin : check_results
        t_weight_result got, want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{net_weight, smoothed_count, in_motion, at_zero};
            if (expected_weights.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result: weight %0d count %0d m%0b z%0b",
                             $realtime, got.net_weight, got.smoothed_count,
                             got.in_motion, got.at_zero);
            end else begin
                want = expected_weights.pop_front();
                if (got.net_weight !== want.net_weight ||
                    got.smoothed_count !== want.smoothed_count ||
                    got.in_motion !== want.in_motion || got.at_zero !== want.at_zero) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch exp %0d %0d m%0b z%0b got %0d %0d m%0b z%0b",
                                 $realtime, want.net_weight, want.smoothed_count,
                                 want.in_motion, want.at_zero, got.net_weight,
                                 got.smoothed_count, got.in_motion, got.at_zero);
                end
            end
        end
    end

    // Stimulus: reset, directed table, random phases, drain, verdict
    initial begin
        int random_start;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (DIRECTED_ROWS[r].kind == ROW_WRITE) begin
                wait_results_drained();
                write_reg(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].data);
            end else begin
                send_count(DIRECTED_ROWS[r].count, DIRECTED_ROWS[r].typed,
                           DIRECTED_ROWS[r].want);
            end
        end
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            configure_random();
            send_segment();
        end
        wait_results_drained();
        // settle time past the longest item latency
        repeat (60) @(posedge clk);
        if (expected_weights.size() != 0) fail_count++;
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
